// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== rtl/core/fgs_pkg.sv =====
// Types, constants and the exp table of the fuzzy gain-scheduled controller
package fgs_pkg;
    localparam int NRULES    = 5;
    localparam int NSTATES   = 4;
    localparam int EXP_DEPTH = 256;
    localparam int LOG2D     = $clog2(EXP_DEPTH);
    localparam int MW        = 17;
    localparam int TW        = 20;
    localparam int QD        = 4;
    localparam int QCW       = $clog2(QD + 1);
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SIGMA = 3'd5;
    localparam logic [15:0] INV_SIGMA_RST = 16'd733;

    localparam logic signed [25:0] CENTRE [NRULES] =
        '{26'sd0, 26'sd2145, -26'sd2145, 26'sd3217, -26'sd3217};

    typedef struct packed {
        logic signed [23:0] tilt_angle;
        logic signed [23:0] tilt_rate;
        logic signed [23:0] wheel_position;
        logic signed [23:0] wheel_velocity;
    } t_item;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               saturated;
    } t_result;

    typedef struct packed {
        logic [NRULES-1:0][MW-1:0] m;
        logic [TW-1:0]             total;
        logic [2:0]                best;
        t_item                     x;
    } t_entry;

    typedef struct packed {
        logic [QCW-1:0] count;
        logic           empty;
    } t_qstat;

    typedef logic [NRULES-1:0][63:0] t_gains;
    typedef logic [MW-1:0] t_rom [EXP_DEPTH];

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] h;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        logic [63:0] v;
        h    = (64'd16 << 32) / EXP_DEPTH;
        term = 64'd1 << 32;
        pos  = 64'd1 << 32;
        neg  = 64'd0;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * h) >> 32) / 64'(n);
            if ((n & 1) != 0) neg = neg + term;
            else pos = pos + term;
        end
        r = pos - neg;
        v = 64'd1 << 32;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            rom[k] = MW'((v + (64'd1 << 15)) >> 16);
            v = (v * r + (64'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM = build_rom();
endpackage

// ===== rtl/core/fgs_front.sv =====
// Front part: three-stage membership pipeline, total and nearest rule
module fgs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  fgs_pkg::t_item i_item,
    input  logic [15:0]    i_inv_sigma,
    output logic           o_push,
    output fgs_pkg::t_entry o_entry,
    output logic [1:0]     o_inflight
);
    import fgs_pkg::*;

    logic [NRULES-1:0][40:0] r_z1;
    logic [NRULES-1:0][24:0] r_absd1, r_absd2, r_absd3;
    logic [NRULES-1:0][43:0] r_zsq2;
    logic [NRULES-1:0]       r_big2;
    logic [NRULES-1:0][MW-1:0] r_m3;
    t_item r_x1, r_x2, r_x3;
    logic  r_v1, r_v2, r_v3;

    logic signed [25:0] d [NRULES];
    logic [NRULES-1:0][24:0] absd;
    logic [TW-1:0] total;
    logic [2:0]    best;

    always_comb begin
        for (int j = 0; j < NRULES; j++) begin
            d[j]    = 26'(i_item.tilt_angle) - CENTRE[j];
            absd[j] = 25'(d[j][25] ? -d[j] : d[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        for (int j = 0; j < NRULES; j++) begin
            r_z1[j]    <= 41'(absd[j]) * 41'(i_inv_sigma);
            r_absd1[j] <= absd[j];
            r_big2[j]  <= |r_z1[j][40:22];
            r_zsq2[j]  <= 44'(r_z1[j][21:0]) * 44'(r_z1[j][21:0]);
            r_absd2[j] <= r_absd1[j];
            r_m3[j]    <= r_big2[j] ? '0 : EXP_ROM[r_zsq2[j][43 -: LOG2D]];
            r_absd3[j] <= r_absd2[j];
        end
        r_x1 <= i_item;
        r_x2 <= r_x1;
        r_x3 <= r_x2;
    end

    // earlier rule wins a tie
    always_comb begin
        total = '0;
        best  = 3'd0;
        for (int j = 0; j < NRULES; j++) total = total + TW'(r_m3[j]);
        for (int j = 1; j < NRULES; j++) begin
            if (r_absd3[j] < r_absd3[best]) best = 3'(j);
        end
    end

    assign o_push        = r_v3;
    assign o_entry.m     = r_m3;
    assign o_entry.total = total;
    assign o_entry.best  = best;
    assign o_entry.x     = r_x3;
    assign o_inflight    = 2'({1'b0, r_v1} + {1'b0, r_v2} + {1'b0, r_v3});
endmodule

// ===== rtl/core/fgs_queue.sv =====
// Short queue of classified words between front and back
module fgs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fgs_pkg::t_entry i_entry,
    input  logic            i_pop,
    output fgs_pkg::t_entry o_entry,
    output fgs_pkg::t_qstat o_stat
);
    import fgs_pkg::*;

    localparam int PW = $clog2(QD);

    t_entry          r_mem [QD];
    logic [PW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + QCW'(i_push) - QCW'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    assign o_entry      = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);
endmodule

// ===== rtl/core/fgs_back.sv =====
// Back part: weight divider, gain blend, state product and output rounding
module fgs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fgs_pkg::t_qstat  i_qstat,
    input  fgs_pkg::t_entry  i_entry,
    input  fgs_pkg::t_gains  i_gains,
    output logic             o_pop,
    output logic             o_valid,
    output fgs_pkg::t_result o_result
);
    import fgs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MAC  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [3:0] r_cnt;
    logic [NRULES-1:0][TW-1:0] r_rem;
    logic [NRULES-1:0][17:0]   r_quo;
    logic [NRULES-1:0][TW-1:0] n_rem;
    logic [NRULES-1:0][17:0]   n_quo;
    logic [TW-1:0] r_total;
    logic [2:0]    r_best;
    logic signed [23:0] r_x [NSTATES];

    logic signed [33:0] r_prod [NRULES];
    logic signed [23:0] r_x1, r_x2;
    logic signed [31:0] r_k;
    logic signed [55:0] r_kx;
    logic signed [57:0] r_acc;
    logic r_v1, r_v2, r_v3;

    logic [NRULES-1:0][MW-1:0] w;
    logic [1:0]         si;
    logic signed [36:0] ksum;
    logic signed [58:0] negv;
    logic signed [38:0] u;
    logic               sat_hi, sat_lo;

    assign o_pop = !i_qstat.empty && ((r_state == S_IDLE) || (r_state == S_FIN));

    // two restoring steps per cycle in each lane
    always_comb begin
        logic [TW-1:0] t;
        logic          b1, b2;
        for (int j = 0; j < NRULES; j++) begin
            t  = r_rem[j];
            b1 = (t >= r_total);
            t  = b1 ? t - r_total : t;
            t  = {t[TW-2:0], 1'b0};
            b2 = (t >= r_total);
            t  = b2 ? t - r_total : t;
            n_rem[j] = {t[TW-2:0], 1'b0};
            n_quo[j] = {r_quo[j][15:0], b1, b2};
        end
    end

    // no membership at all: nearest rule takes full weight
    always_comb begin
        for (int j = 0; j < NRULES; j++) begin
            if (r_total == '0) w[j] = (r_best == 3'(j)) ? MW'(65536) : '0;
            else w[j] = r_quo[j][17:1];
        end
    end

    assign si = r_cnt[1:0];

    always_comb begin
        ksum = '0;
        for (int j = 0; j < NRULES; j++) ksum = ksum + 37'(r_prod[j]);
    end

    assign negv   = -59'(r_acc) + 59'sd524288;
    assign u      = 39'(negv >>> 20);
    assign sat_hi = (u > 39'sd2147483647);
    assign sat_lo = (u < -39'sd2147483648);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == S_FIN);
            r_v1    <= (r_state == S_MAC) && (r_cnt < 4'd4);
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end
                end
                S_DIV: begin
                    r_cnt <= (r_cnt == 4'd8) ? '0 : r_cnt + 1'b1;
                    if (r_cnt == 4'd8) r_state <= S_MAC;
                end
                S_MAC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd6) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_cnt   <= '0;
                    r_state <= o_pop ? S_DIV : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int j = 0; j < NRULES; j++) begin
                r_rem[j] <= TW'(i_entry.m[j]);
                r_quo[j] <= '0;
            end
            r_total <= i_entry.total;
            r_best  <= i_entry.best;
            r_x[0]  <= i_entry.x.tilt_angle;
            r_x[1]  <= i_entry.x.tilt_rate;
            r_x[2]  <= i_entry.x.wheel_position;
            r_x[3]  <= i_entry.x.wheel_velocity;
            r_acc   <= '0;
        end else begin
            if (r_state == S_DIV) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
            end
            if (r_v3) r_acc <= r_acc + 58'(r_kx);
        end
        for (int j = 0; j < NRULES; j++) begin
            r_prod[j] <= 34'($signed({1'b0, w[j]}))
                       * 34'($signed(i_gains[j][{si, 4'b0000} +: 16]));
        end
        r_x1 <= r_x[si];
        r_k  <= 32'(ksum);
        r_x2 <= r_x1;
        r_kx <= 56'(r_k) * 56'(r_x2);
        if (r_state == S_FIN) begin
            o_result.saturated <= sat_hi || sat_lo;
            o_result.drive     <= sat_hi ? 32'sh7FFFFFFF :
                                  sat_lo ? 32'sh80000000 : 32'(u);
        end
    end
endmodule

// ===== rtl/core/fuzzy_gain_scheduled_state_feedback.sv =====
// Top level of the fuzzy gain-scheduled state feedback controller
// Usage:
//   Drive start with a state word on i_item (tilt angle, tilt rate, wheel
//   position, wheel velocity, all Q12.12). The word is taken at a clock
//   edge where start is high and busy is low.
//   The drive word (Q16.16, saturated, with its clip flag) appears on
//   o_result, marked by o_valid high for exactly one cycle. The receiver cannot
//   stall; every result must be captured in that cycle.
//   Configuration: pulse i_cfg_we with i_cfg_idx 0..4 for the five gain rows
//   (0, +30, -30, +45, -45 degrees) or 5 for inv_sigma. Write only while idle.
// Timing:
//   An accepted word passes the membership pipeline and the queue, then the
//   back part: a weight divider (two quotient bits per cycle), a blend loop
//   over the four states and a rounding state that registers the result.
//   The back part takes the next word from the queue only in its rounding
//   state or when idle. The front part takes a word every cycle until the
//   queue and pipeline hold four words.
// Reset: gains clear, inv_sigma returns to 733, queue and pipelines empty.
`include "assert_macros.svh"
module fuzzy_gain_scheduled_state_feedback (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  fgs_pkg::t_item                    i_item,
    output logic                              o_valid,
    output fgs_pkg::t_result                  o_result,
    input  logic                              i_cfg_we,
    input  logic [fgs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [63:0]                       i_cfg_data
);
    import fgs_pkg::*;

    t_gains      r_gains;
    logic [15:0] r_inv_sigma;

    logic   accept;
    logic   push;
    t_entry f_entry;
    t_entry q_entry;
    t_qstat q_stat;
    logic [1:0] inflight;
    logic   pop;

    // hold config registers; ignore unused indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains     <= '0;
            r_inv_sigma <= INV_SIGMA_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_INV_SIGMA) r_inv_sigma <= i_cfg_data[15:0];
            else if (i_cfg_idx < CFG_IDX_W'(NRULES)) r_gains[i_cfg_idx] <= i_cfg_data;
        end
    end

    // stall the front once the queue plus words in flight fill the queue
    assign busy   = ({1'b0, q_stat.count} + (QCW + 1)'(inflight)) >= (QCW + 1)'(QD);
    assign accept = start && !busy;

    fgs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_inv_sigma(r_inv_sigma),
        .o_push     (push),
        .o_entry    (f_entry),
        .o_inflight (inflight)
    );

    fgs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(f_entry),
        .i_pop  (pop),
        .o_entry(q_entry),
        .o_stat (q_stat)
    );

    fgs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (q_stat),
        .i_entry (q_entry),
        .i_gains (r_gains),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    `ASSERT_IMPLIES(a_sat_clip, i_clk, i_rst_n, o_valid && o_result.saturated, (o_result.drive == 32'sh7FFFFFFF) || (o_result.drive == 32'sh80000000))
    `ASSERT_IMPLIES(a_queue_bound, i_clk, i_rst_n, 1'b1, q_stat.count <= QCW'(QD))
    `ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, push, q_stat.count < QCW'(QD))
endmodule

// ===== tb/tb.sv =====
// Testbench for the fuzzy gain-scheduled state feedback controller
`timescale 1ns / 100ps
module tb;
    import fgs_pkg::*;

    localparam int ROM_N = 256;

    // Register indexes as the block decodes them; six and seven are unused
    localparam logic [2:0] REG_ROW0     = 3'd0;
    localparam logic [2:0] REG_SIGMA    = 3'd5;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_valid;
    t_result     o_result;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    fuzzy_gain_scheduled_state_feedback dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the configuration registers
    logic [63:0] gain_rows [NRULES];
    logic [15:0] sigma_recip;
    logic [31:0] gauss_tab [ROM_N];

    t_result     drive_expect_q [$];
    int          mismatches;
    int          words_sent;
    int          words_checked;
    int          sat_seen;

    // Build exp(-16k/N) in Q1.16 from a truncated Taylor ratio kept in Q0.32
    task automatic fill_gauss_tab();
        logic [63:0] step;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] ratio;
        logic [63:0] acc;
        step = (64'd16 << 32) / ROM_N;
        term = 64'd1 << 32;
        pos  = term;
        neg  = 0;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * step) >> 32) / 64'(n);
            if (n % 2 == 1) neg += term;
            else pos += term;
        end
        ratio = pos - neg;
        acc   = 64'd1 << 32;
        for (int k = 0; k < ROM_N; k++) begin
            gauss_tab[k] = 32'((acc + (64'd1 << 15)) >> 16);
            acc = (acc * ratio + (64'd1 << 31)) >> 32;
        end
    endtask

    function automatic longint unsigned grade(longint unsigned span);
        longint unsigned z;
        longint unsigned k;
        z = span * sigma_recip;
        if (z >= (64'd4 << 20)) return 0;
        k = (z * z * ROM_N) >> 44;
        if (k >= ROM_N) return 0;
        return gauss_tab[k];
    endfunction

    // Blend the gain rows by angle and form the saturated drive word
    function automatic t_result control_law(t_item x);
        longint          st [NSTATES];
        longint          centre [NRULES];
        longint unsigned span [NRULES];
        longint unsigned mem [NRULES];
        longint unsigned wt [NRULES];
        longint unsigned total;
        longint          kk;
        longint          acc;
        longint          u;
        logic [15:0]     g;
        int              near;
        t_result         r;
        centre = '{0, 2145, -2145, 3217, -3217};
        st[0] = x.tilt_angle;
        st[1] = x.tilt_rate;
        st[2] = x.wheel_position;
        st[3] = x.wheel_velocity;
        total = 0;
        near  = 0;
        for (int j = 0; j < NRULES; j++) begin
            kk = st[0] - centre[j];
            span[j] = (kk < 0) ? -kk : kk;
            mem[j]  = grade(span[j]);
            total  += mem[j];
            if (span[j] < span[near]) near = j;
        end
        for (int j = 0; j < NRULES; j++)
            wt[j] = (total == 0) ? ((j == near) ? 65536 : 0) : (mem[j] << 16) / total;
        acc = 0;
        for (int i = 0; i < NSTATES; i++) begin
            kk = 0;
            for (int j = 0; j < NRULES; j++) begin
                g = gain_rows[j][16*i +: 16];
                kk += longint'(wt[j]) * longint'($signed(g));
            end
            acc += kk * st[i];
        end
        u = (-acc + (64'sd1 <<< 19)) >>> 20;
        r.saturated = 1'b0;
        if (u > 64'sd2147483647) begin
            u = 64'sd2147483647;
            r.saturated = 1'b1;
        end
        if (u < -64'sd2147483648) begin
            u = -64'sd2147483648;
            r.saturated = 1'b1;
        end
        r.drive = u[31:0];
        return r;
    endfunction

    // Check every strobed drive word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (drive_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: drive %h sat %b",
                             o_result.drive, o_result.saturated);
            end else begin
                t_result e;
                e = drive_expect_q.pop_front();
                words_checked++;
                if (o_result.saturated) sat_seen++;
                if (o_result.drive !== e.drive || o_result.saturated !== e.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: drive exp %h got %h, sat exp %b got %b",
                                 e.drive, o_result.drive, e.saturated, o_result.saturated);
                end
            end
        end
    end

    // Hand one word to the block; hold start high until it is taken
    task automatic send_word(t_item x, bit typed, t_result typed_res);
        start  <= 1'b1;
        i_item <= x;
        do @(posedge i_clk); while (busy);
        drive_expect_q.push_back(typed ? typed_res : control_law(x));
        words_sent++;
    endtask

    // Close a burst: drop start and idle a random gap
    task automatic idle_gap(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drain all pending words, then let the pipeline settle
    task automatic drain();
        start <= 1'b0;
        while (drive_expect_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx < NRULES) gain_rows[idx] = data;
        else if (idx == REG_SIGMA) sigma_recip = data[15:0];
    endtask

    task automatic set_config(logic [63:0] rows [NRULES], logic [63:0] sigma);
        for (int j = 0; j < NRULES; j++) write_reg(REG_ROW0 + 3'(j), rows[j]);
        write_reg(REG_SIGMA, sigma);
        write_reg(REG_SPARE_LO, {$urandom, $urandom});
        write_reg(REG_SPARE_HI, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_item mk(longint a, longint b, longint c, longint d);
        t_item x;
        x.tilt_angle     = a[23:0];
        x.tilt_rate      = b[23:0];
        x.wheel_position = c[23:0];
        x.wheel_velocity = d[23:0];
        return x;
    endfunction

    function automatic logic [23:0] any24();
        return 24'($urandom);
    endfunction

    // Angles mostly near the rule centres, with full-range noise
    function automatic t_item rand_word();
        t_item x;
        int    pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) x.tilt_angle = 24'($signed($urandom_range(0, 8000)) - 4000);
        else if (pick < 8) x.tilt_angle = 24'($signed($urandom_range(0, 40000)) - 20000);
        else x.tilt_angle = any24();
        if ($urandom_range(0, 1)) begin
            x.tilt_rate      = any24();
            x.wheel_position = any24();
            x.wheel_velocity = any24();
        end else begin
            x.tilt_rate      = 24'($signed($urandom_range(0, 16384)) - 8192);
            x.wheel_position = 24'($signed($urandom_range(0, 16384)) - 8192);
            x.wheel_velocity = 24'($signed($urandom_range(0, 16384)) - 8192);
        end
        return x;
    endfunction

    typedef struct {
        t_item   x;
        bit      typed;
        t_result r;
    } t_row;

    initial begin
        #2_000_000;
        $display("** fuzzy_gain_scheduled_state_feedback: FAILED **");
        $finish;
    end

    initial begin
        t_row        plan [$];
        t_result     zero_res;
        logic [63:0] rows [NRULES];
        longint      mx;
        longint      mn;
        int          burst;
        i_clk      = 1'b0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        mismatches    = 0;
        words_sent    = 0;
        words_checked = 0;
        sat_seen      = 0;
        for (int j = 0; j < NRULES; j++) gain_rows[j] = '0;
        sigma_recip = 16'd733;
        fill_gauss_tab();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        mx = 8388607;
        mn = -8388608;
        zero_res = '0;

        // Reset gains are zero, so every drive word is zero without saturation
        plan.push_back('{mk(0, 0, 0, 0), 1, zero_res});
        plan.push_back('{mk(mx, mx, mx, mx), 1, zero_res});
        plan.push_back('{mk(mn, mn, mn, mn), 1, zero_res});
        plan.push_back('{mk(2145, mx, mn, 1), 1, zero_res});
        plan.push_back('{mk(-3217, -1, 1, mn), 1, zero_res});
        foreach (plan[i]) send_word(plan[i].x, plan[i].typed, plan[i].r);
        drain();

        // Largest gains with a very narrow membership: exercise the nearest-rule
        // fallback, its ties, and saturation at both ends
        rows = '{64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                 64'h0100_FF00_0001_FFFF, 64'h1234_8765_7FFF_0000,
                 64'hFFFF_FFFF_FFFF_FFFF};
        set_config(rows, 64'hFFFF);
        plan.delete();
        plan.push_back('{mk(2681, 0, 0, 0), 0, zero_res});
        plan.push_back('{mk(-2681, 4096, 4096, 4096), 0, zero_res});
        plan.push_back('{mk(mx, mx, mx, mx), 0, zero_res});
        plan.push_back('{mk(mn, mn, mn, mn), 0, zero_res});
        plan.push_back('{mk(mn, mx, mn, mx), 0, zero_res});
        plan.push_back('{mk(0, -4096, 4096, -1), 0, zero_res});
        plan.push_back('{mk(1072, 1, 1, 1), 0, zero_res});
        plan.push_back('{mk(3217, 100, -100, 7), 0, zero_res});
        foreach (plan[i]) send_word(plan[i].x, plan[i].typed, plan[i].r);
        drain();

        // Zero reciprocal width: all five weights equal
        set_config(rows, 64'h0);
        plan.delete();
        plan.push_back('{mk(0, 4096, 4096, 4096), 0, zero_res});
        plan.push_back('{mk(mx, 1, -1, 0), 0, zero_res});
        plan.push_back('{mk(mn, -4096, 0, 4096), 0, zero_res});
        plan.push_back('{mk(2145, 12, 34, 56), 0, zero_res});
        foreach (plan[i]) send_word(plan[i].x, plan[i].typed, plan[i].r);
        drain();

        // Random phases over several widths, the extremes among them
        for (int ph = 0; ph < 6; ph++) begin
            for (int j = 0; j < NRULES; j++) begin
                rows[j] = {$urandom, $urandom};
                if (ph == 1) rows[j] = {4{16'h0100 + 16'($urandom_range(0, 255))}};
            end
            case (ph)
                0: set_config(rows, 64'd733);
                1: set_config(rows, 64'd1);
                2: set_config(rows, 64'hFFFF);
                3: set_config(rows, 64'd0);
                default: set_config(rows, {$urandom, 16'($urandom_range(1, 4000))});
            endcase
            for (int n = 0; n < 84; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++, n++) send_word(rand_word(), 0, zero_res);
                if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 30));
            end
            drain();
        end

        $display("sent %0d words over nine configurations, checked %0d drive words",
                 words_sent, words_checked);
        $display("saturated drive words seen: %0d, mismatches: %0d", sat_seen, mismatches);
        if (mismatches == 0 && drive_expect_q.size() == 0)
            $display("** fuzzy_gain_scheduled_state_feedback: PASSED **");
        else
            $display("** fuzzy_gain_scheduled_state_feedback: FAILED **");
        $finish;
    end
endmodule
